/* sv/triangle_point_location_defines.svh */
// ----------------------------------------------------------------------------
// Triangle point location: assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_POINT_LOCATION_DEFINES_SVH
`define TRIANGLE_POINT_LOCATION_DEFINES_SVH

// Same-cycle implication.
`define TPL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("triangle point location assertion failed");

// Next-cycle implication.
`define TPL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("triangle point location assertion failed");

`endif

/* sv/tpl_pkg.sv */
// ----------------------------------------------------------------------------
// Triangle point location package
// Sizes, request codes, vertex and edge-sign types used by the edge cell, top level and testbench.
// ----------------------------------------------------------------------------
`default_nettype none

package tpl_pkg;

    localparam int MAX_TRIANGLES = 1024;
    localparam int COORD_BITS    = 32;
    localparam int FIELD_W       = 32;
    localparam int CFG_W         = 11;
    localparam int SLOT_W        = 10;
    localparam int CORNER_W      = 2;
    localparam int REQ_W         = 2;
    localparam int WIN_W         = 31;
    localparam int IDX_W         = 10;
    localparam int ADDR_W        = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int CNT_W         = $clog2(MAX_TRIANGLES + 1);
    localparam int DIFF_W        = COORD_BITS + 1;
    localparam int PROD_W        = 2 * DIFF_W;
    localparam int CROSS_W       = PROD_W + 1;
    localparam int HY_W          = COORD_BITS + 3;
    localparam int LIM_W         = WIN_W + 2;

    localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FIRST   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLOSEST = 2'd2;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vertex;

    localparam int VERT_W = $bits(t_vertex);

    typedef struct packed {
        logic pos;
        logic neg;
    } t_sign;

    function automatic t_coord narrow(input logic [FIELD_W-1:0] v);
        return v[COORD_BITS-1:0];
    endfunction

    function automatic logic [DIFF_W-1:0] diff(input t_coord a, input t_coord b);
        return {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    endfunction

endpackage

`default_nettype wire

/* sv/tpl_req_if.sv */
// ----------------------------------------------------------------------------
// Triangle point location request channel
// Valid/ready channel carrying one request word.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpl_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  req_type;
    logic [9:0]                  slot;
    logic [1:0]                  corner;
    logic signed [31:0]          coord_x;
    logic signed [31:0]          coord_y;
    logic signed [31:0]          coord_z;
    logic [30:0]                 height_window;

    modport source (output valid, req_type, slot, corner, coord_x, coord_y, coord_z,
                    height_window, input ready);
    modport sink   (input valid, req_type, slot, corner, coord_x, coord_y, coord_z,
                    height_window, output ready);
endinterface

`default_nettype wire

/* sv/tpl_rsp_if.sv */
// ----------------------------------------------------------------------------
// Triangle point location response channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpl_rsp_if;
    logic       valid;
    logic       ready;
    logic       hit;
    logic [9:0] hit_index;

    modport source (output valid, hit, hit_index, input ready);
    modport sink   (input valid, hit, hit_index, output ready);
endinterface

`default_nettype wire

/* sv/tpl_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* sv/tpl_edge_cell.sv */
// ----------------------------------------------------------------------------
// Triangle point location edge cell
// Three-stage exact XZ cross product of one edge against the point.
// ----------------------------------------------------------------------------
`default_nettype none

module tpl_edge_cell (
    input  wire logic             i_clk,
    input  wire tpl_pkg::t_vertex i_a,
    input  wire tpl_pkg::t_vertex i_b,
    input  wire tpl_pkg::t_coord  i_px,
    input  wire tpl_pkg::t_coord  i_pz,
    output tpl_pkg::t_sign        o_sign
);
    import tpl_pkg::*;

    logic signed [DIFF_W-1:0]  r_u1, r_v1, r_u2, r_v2;
    logic signed [PROD_W-1:0]  r_p1, r_p2;
    logic signed [CROSS_W-1:0] r_cross;

    always_ff @(posedge i_clk) begin
        r_u1    <= diff(i_b.x, i_a.x);
        r_v1    <= diff(i_pz, i_a.z);
        r_u2    <= diff(i_b.z, i_a.z);
        r_v2    <= diff(i_px, i_a.x);
        r_p1    <= r_u1 * r_v1;
        r_p2    <= r_u2 * r_v2;
        r_cross <= {r_p1[PROD_W-1], r_p1} - {r_p2[PROD_W-1], r_p2};
    end

    assign o_sign.neg = r_cross[CROSS_W-1];
    assign o_sign.pos = !r_cross[CROSS_W-1] && (|r_cross);

endmodule

`default_nettype wire

/* sv/triangle_point_location.sv */
// A load word is answered in the cycle after acceptance; it writes the vertex RAM
// of its corner (none for corner 3). A query word reads one triangle from the
// vertex RAMs per cycle and passes it through the three-stage edge cells.
// No new word is accepted while a query scan is in progress.
// Reset is synchronous, active low; it clears control state and the count only.
// ----------------------------------------------------------------------------
// Triangle point location top level
// Scans a vertex table for triangles whose XZ projection holds a point.
// ----------------------------------------------------------------------------
`default_nettype none
`include "triangle_point_location_defines.svh"

module triangle_point_location (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    tpl_req_if.sink                        i_req,
    tpl_rsp_if.source                      o_rsp,
    input  wire logic                      i_cfg_we,
    input  wire logic [tpl_pkg::CFG_W-1:0] i_cfg_data
);
    import tpl_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN} t_state;

    localparam int STG = 4;

    t_state              r_state;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_addr;
    logic [REQ_W-1:0]    r_req;
    t_coord              r_px, r_pz;
    logic [HY_W-1:0]     r_py3;
    logic [LIM_W-1:0]    r_lim;
    logic [STG:1]        r_vld, r_last;
    logic [ADDR_W-1:0]   r_tag [1:STG];
    logic [HY_W-1:0]     r_dy, r_ady, r_ady4;
    logic                r_ok;
    logic                r_hit;
    logic [HY_W-1:0]     r_best;
    logic [ADDR_W-1:0]   r_idx;
    logic                r_out_valid, r_out_hit;
    logic [ADDR_W-1:0]   r_out_idx;

    logic                w_accept, w_issue, w_holds, w_take;
    t_vertex             w_v [3];
    t_sign               w_s [3];
    logic [VERT_W-1:0]   w_wdata;
    logic [HY_W-1:0]     w_ysum;
    logic [HY_W-1:0]     w_py3;

    assign i_req.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_issue     = (r_state == S_SCAN);
    assign w_wdata     = {narrow(i_req.coord_x), narrow(i_req.coord_y), narrow(i_req.coord_z)};

    for (genvar k = 0; k < 3; k++) begin : g_corner
        logic [VERT_W-1:0] w_rd;
        logic              w_we;
        assign w_we = w_accept && (i_req.req_type == REQ_LOAD)
                      && (i_req.corner == CORNER_W'(k))
                      && (32'(i_req.slot) < 32'(MAX_TRIANGLES));
        tpl_ram #(.WIDTH(VERT_W), .DEPTH(MAX_TRIANGLES)) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_waddr (ADDR_W'(i_req.slot)),
            .i_wdata (w_wdata),
            .i_raddr (r_addr[ADDR_W-1:0]),
            .o_rdata (w_rd)
        );
        assign w_v[k] = t_vertex'(w_rd);
        tpl_edge_cell u_cell (
            .i_clk  (i_clk),
            .i_a    (w_v[k]),
            .i_b    (w_v[(k + 1) % 3]),
            .i_px   (r_px),
            .i_pz   (r_pz),
            .o_sign (w_s[k])
        );
    end

    assign w_ysum = HY_W'($signed(w_v[0].y)) + HY_W'($signed(w_v[1].y))
                    + HY_W'($signed(w_v[2].y));
    assign w_py3  = (HY_W'($signed(narrow(i_req.coord_y))) << 1)
                    + HY_W'($signed(narrow(i_req.coord_y)));

    assign w_holds = !((w_s[0].neg || w_s[1].neg || w_s[2].neg)
                       && (w_s[0].pos || w_s[1].pos || w_s[2].pos));

    always_comb begin
        w_take = 1'b0;
        case (r_req)
            REQ_FIRST:   w_take = w_holds && !r_hit;
            REQ_CLOSEST: w_take = w_holds && r_ok && (!r_hit || (r_ady4 < r_best));
            default:     w_take = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_tag[1] <= r_addr[ADDR_W-1:0];
        for (int s = 2; s <= STG; s++) begin
            r_tag[s] <= r_tag[s-1];
        end
        r_dy   <= r_py3 - w_ysum;
        r_ady  <= r_dy[HY_W-1] ? (HY_W'(0) - r_dy) : r_dy;
        r_ady4 <= r_ady;
        r_ok   <= r_ady <= HY_W'(r_lim);

        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_addr      <= '0;
            r_vld       <= '0;
            r_last      <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= (32'(i_cfg_data) > 32'(MAX_TRIANGLES)) ?
                           CNT_W'(MAX_TRIANGLES) : CNT_W'(i_cfg_data);
            end
            r_vld  <= {r_vld[STG-1:1], w_issue};
            r_last <= {r_last[STG-1:1], w_issue && (r_addr == r_count - CNT_W'(1))};

            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            if (r_vld[STG] && w_take) begin
                r_hit  <= 1'b1;
                r_best <= r_ady4;
                r_idx  <= r_tag[STG];
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_req  <= i_req.req_type;
                        r_px   <= narrow(i_req.coord_x);
                        r_pz   <= narrow(i_req.coord_z);
                        r_py3  <= w_py3;
                        r_lim  <= (LIM_W'(i_req.height_window) << 1)
                                  + LIM_W'(i_req.height_window);
                        r_hit  <= 1'b0;
                        r_addr <= '0;
                        if (((i_req.req_type == REQ_FIRST)
                             || (i_req.req_type == REQ_CLOSEST)) && (r_count != '0)) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_out_hit   <= 1'b0;
                            r_out_idx   <= '0;
                        end
                    end
                end
                S_SCAN: begin
                    r_addr <= r_addr + CNT_W'(1);
                    if (r_addr == r_count - CNT_W'(1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (r_vld[STG] && r_last[STG]) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b1;
                        r_out_hit   <= r_hit || w_take;
                        r_out_idx   <= w_take ? r_tag[STG] : (r_hit ? r_idx : '0);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.hit       = r_out_hit;
    assign o_rsp.hit_index = IDX_W'(r_out_idx);

    `TPL_ASSERT_IMP(a_pipe_busy, i_clk, i_rst_n, r_vld[STG], r_state != S_IDLE)
    `TPL_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n, r_out_valid && !r_out_hit, r_out_idx == '0)
    `TPL_ASSERT_IMP(a_scan_range, i_clk, i_rst_n, r_state == S_SCAN, r_addr < r_count)
    `TPL_ASSERT_NXT(a_finish, i_clk, i_rst_n,
                    (r_state == S_DRAIN) && r_vld[STG] && r_last[STG],
                    (r_state == S_IDLE) && r_out_valid)

endmodule

`default_nettype wire

/* tb/sv/triangle_point_location_test.sv */
// ----------------------------------------------------------------------------
// Triangle point location testbench
// Loads triangle tables, scans them with first-hit and closest-height
// queries under random source gaps and sink stalls, and compares every
// result word with an exact integer predictor held in a scoreboard.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_point_location_test;
    import tpl_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNDEF = 2'd3;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct {
        logic [REQ_W-1:0] req_type;
        logic [9:0]       slot;
        logic [1:0]       corner;
        logic [31:0]      x;
        logic [31:0]      y;
        logic [31:0]      z;
        logic [30:0]      win;
    } t_word;

    class t_scoreboard;
        logic signed [31:0] vx [MAX_TRIANGLES][3];
        logic signed [31:0] vy [MAX_TRIANGLES][3];
        logic signed [31:0] vz [MAX_TRIANGLES][3];
        int unsigned scan_len;
        logic [10:0] answers [$];
        int errors;

        function void set_count(int unsigned v);
            scan_len = (v > MAX_TRIANGLES) ? MAX_TRIANGLES : v;
        endfunction

        function int edge_sign(longint ax, longint az, longint bx, longint bz,
                               longint px, longint pz);
            logic signed [67:0] u1, v1, u2, v2, c;
            u1 = bx - ax;
            v1 = pz - az;
            u2 = bz - az;
            v2 = px - ax;
            c = u1 * v1 - u2 * v2;
            return (c > 0) ? 1 : ((c < 0) ? -1 : 0);
        endfunction

        function bit holds(int t, longint px, longint pz);
            int s [3];
            bit neg, pos;
            for (int k = 0; k < 3; k++) begin
                s[k] = edge_sign(vx[t][k], vz[t][k], vx[t][(k+1)%3], vz[t][(k+1)%3],
                                 px, pz);
            end
            neg = (s[0] < 0) || (s[1] < 0) || (s[2] < 0);
            pos = (s[0] > 0) || (s[1] > 0) || (s[2] > 0);
            return !(neg && pos);
        endfunction

        function void note(t_word w);
            longint px, py, pz, d, best, lim;
            bit hit;
            int idx;
            px = longint'($signed(w.x));
            py = longint'($signed(w.y));
            pz = longint'($signed(w.z));
            hit = 0;
            idx = 0;
            best = 0;
            if (w.req_type == REQ_LOAD) begin
                if (w.corner < 3) begin
                    vx[w.slot][w.corner] = w.x;
                    vy[w.slot][w.corner] = w.y;
                    vz[w.slot][w.corner] = w.z;
                end
            end else if (w.req_type == REQ_FIRST) begin
                for (int t = 0; t < scan_len && !hit; t++) begin
                    if (holds(t, px, pz)) begin
                        hit = 1;
                        idx = t;
                    end
                end
            end else if (w.req_type == REQ_CLOSEST) begin
                lim = 3 * longint'(w.win);
                for (int t = 0; t < scan_len; t++) begin
                    if (holds(t, px, pz)) begin
                        d = 3 * py - (longint'(vy[t][0]) + longint'(vy[t][1])
                                      + longint'(vy[t][2]));
                        if (d < 0) d = -d;
                        if (d <= lim && (!hit || d < best)) begin
                            hit = 1;
                            best = d;
                            idx = t;
                        end
                    end
                end
            end
            answers.insert(answers.size(), {hit, hit ? idx[9:0] : 10'd0});
        endfunction

        function void check(logic hit, logic [9:0] hit_index);
            logic [10:0] want;
            if (answers.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word hit=%0b index=%0d",
                                           hit, hit_index);
                return;
            end
            want = answers.pop_front();
            if (hit !== want[10] || hit_index !== want[9:0]) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: expected hit=%0b index=%0d, got hit=%0b index=%0d",
                             want[10], want[9:0], hit, hit_index);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_W-1:0] i_cfg_data;
    int unsigned cycles;
    int burst_left;
    int stall_mode;
    t_scoreboard sb;

    tpl_req_if req_ch ();
    tpl_rsp_if rsp_ch ();

    triangle_point_location DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("triangle_point_location_test: errors");
            $finish;
        end
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) sb.check(rsp_ch.hit, rsp_ch.hit_index);
    end

    always @(negedge i_clk) begin
        if (($urandom % 200) == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: rsp_ch.ready = 1'b1;
            1: rsp_ch.ready = ($urandom % 4) != 0;
            2: rsp_ch.ready = ($urandom % 4) == 0;
            default: rsp_ch.ready = (cycles % 7) < 3;
        endcase
    end

    task automatic send_word(input t_word w);
        @(negedge i_clk);
        req_ch.valid         = 1'b1;
        req_ch.req_type      = w.req_type;
        req_ch.slot          = w.slot;
        req_ch.corner        = w.corner;
        req_ch.coord_x       = w.x;
        req_ch.coord_y       = w.y;
        req_ch.coord_z       = w.z;
        req_ch.height_window = w.win;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note(w);
        burst_left--;
        if (burst_left <= 0) begin
            @(negedge i_clk);
            req_ch.valid = 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge i_clk);
            burst_left = (($urandom % 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
        end
    endtask

    task automatic write_count(input int unsigned v);
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (sb.answers.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = v[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.set_count(v);
    endtask

    function automatic t_word load_word(int slot, int corner, logic [31:0] x,
                                        logic [31:0] y, logic [31:0] z);
        t_word w;
        w.req_type = REQ_LOAD;
        w.slot = 10'(slot);
        w.corner = 2'(corner);
        w.x = x;
        w.y = y;
        w.z = z;
        w.win = 31'($urandom);
        return w;
    endfunction

    function automatic t_word query_word(logic [REQ_W-1:0] rt, logic [31:0] x,
                                         logic [31:0] y, logic [31:0] z,
                                         logic [30:0] win);
        t_word w;
        w.req_type = rt;
        w.slot = 10'($urandom);
        w.corner = 2'($urandom);
        w.x = x;
        w.y = y;
        w.z = z;
        w.win = win;
        return w;
    endfunction

    function automatic logic [31:0] coord_value(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
            default: return 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
        endcase
    endfunction

    task automatic fill_slots(input int n);
        int mode;
        for (int t = 0; t < n; t++) begin
            mode = (($urandom % 6) == 0) ? 0 : $urandom_range(1, 2);
            for (int c = 0; c < 3; c++) begin
                send_word(load_word(t, c, coord_value(mode), coord_value(2), coord_value(mode)));
            end
        end
    endtask

    function automatic t_word random_word(int unsigned n);
        t_word w;
        int pick, t, j;
        longint cx, cy, cz;
        logic [30:0] win;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: win = 31'd0;
            1: win = 31'($urandom);
            default: win = 31'($urandom_range(0, 1 << 18));
        endcase
        if (pick < 25) begin
            return load_word($urandom, $urandom_range(0, 3), coord_value($urandom_range(0, 2)),
                             coord_value(2), coord_value($urandom_range(0, 2)));
        end
        if (pick < 30) begin
            return query_word(REQ_UNDEF, $urandom, $urandom, $urandom, 31'($urandom));
        end
        w = query_word((pick < 65) ? REQ_FIRST : REQ_CLOSEST, coord_value($urandom_range(0, 2)),
                       coord_value($urandom_range(0, 2)), coord_value($urandom_range(0, 2)), win);
        if (n > 0 && ($urandom % 10) < 7) begin
            t = $urandom_range(0, n - 1);
            case ($urandom_range(0, 2))
                0: begin
                    cx = (longint'(sb.vx[t][0]) + sb.vx[t][1] + sb.vx[t][2]) / 3;
                    cz = (longint'(sb.vz[t][0]) + sb.vz[t][1] + sb.vz[t][2]) / 3;
                end
                1: begin
                    j = $urandom_range(0, 2);
                    cx = sb.vx[t][j];
                    cz = sb.vz[t][j];
                end
                default: begin
                    cx = (longint'(sb.vx[t][0]) + sb.vx[t][1]) >>> 1;
                    cz = (longint'(sb.vz[t][0]) + sb.vz[t][1]) >>> 1;
                end
            endcase
            cy = (longint'(sb.vy[t][0]) + sb.vy[t][1] + sb.vy[t][2]) / 3;
            w.x = cx[31:0];
            w.z = cz[31:0];
            if ($urandom % 2) w.y = cy[31:0] + ($urandom % 5000) - 2500;
        end
        return w;
    endfunction

    initial begin
        logic [31:0] lo, hi;
        int unsigned settings [4];
        settings = '{16, 5, 1, 24};
        sb = new();
        sb.errors = 0;
        sb.set_count(0);
        burst_left = 4;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_LOAD;
        req_ch.slot = '0;
        req_ch.corner = '0;
        req_ch.coord_x = '0;
        req_ch.coord_y = '0;
        req_ch.coord_z = '0;
        req_ch.height_window = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        lo = 32'h8000_0000;
        hi = 32'h7fff_ffff;
        send_word(query_word(REQ_FIRST, 0, 0, 0, 0));
        send_word(query_word(REQ_UNDEF, hi, lo, hi, 31'h7fff_ffff));
        send_word(load_word(1023, 2, hi, hi, lo));
        send_word(load_word(1023, 3, lo, lo, lo));
        send_word(load_word(0, 0, lo, lo, lo));
        send_word(load_word(0, 1, hi, hi, lo));
        send_word(load_word(0, 2, lo, 0, hi));
        send_word(load_word(1, 0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000));
        send_word(load_word(1, 1, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000));
        send_word(load_word(1, 2, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000));
        send_word(load_word(2, 0, 0, 32'h0000_1000, 0));
        send_word(load_word(2, 1, 32'h0004_0000, 32'h0000_1000, 32'h0004_0000));
        send_word(load_word(2, 2, 32'h0002_0000, 32'h0000_1000, 32'h0002_0000));
        write_count(3);
        send_word(query_word(REQ_FIRST, lo, 0, lo, 0));
        send_word(query_word(REQ_FIRST, hi, 0, hi, 0));
        send_word(query_word(REQ_FIRST, 32'h0001_0000, 0, 32'h0003_0000, 0));
        send_word(query_word(REQ_CLOSEST, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0));
        send_word(query_word(REQ_CLOSEST, 32'h0003_0000, 32'h0000_1000, 32'h0003_0000, 0));
        send_word(query_word(REQ_CLOSEST, 32'h0001_0000, hi, 32'h0003_0000, 31'h7fff_ffff));
        send_word(query_word(REQ_CLOSEST, lo, lo, lo, 31'h7fff_ffff));
        send_word(query_word(REQ_FIRST, hi, lo, lo, 0));

        foreach (settings[s]) begin
            write_count(0);
            fill_slots(settings[s]);
            write_count(settings[s]);
            repeat (105) send_word(random_word(settings[s]));
        end

        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (sb.answers.size() != 0) @(negedge i_clk);
        repeat (MAX_TRIANGLES + 20) @(negedge i_clk);
        if (sb.errors == 0 && sb.answers.size() == 0) begin
            $display("triangle_point_location_test: clean");
        end else begin
            $display("triangle_point_location_test: errors");
        end
        $finish;
    end
endmodule

`default_nettype wire
